// ===== src/time_ordered_hit_chainer_assert.svh =====
// Assertion macros for the hit chainer port checker (tohc_checker).
`ifndef TIME_ORDERED_HIT_CHAINER_ASSERT_SVH
`define TIME_ORDERED_HIT_CHAINER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TOHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hit chainer check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define TOHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hit chainer check failed: next-cycle rule");

`endif

// ===== src/tohc_pkg.sv =====
package tohc_pkg;

   // Fixed field widths
   localparam int COORD_W    = 8;
   localparam int WIN_W      = 8;
   localparam int TRACK_ID_W = 6;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_WINDOW = 2'd2;

   localparam logic [WIN_W-1:0] WIN_RESET = 8'd1;

   // Three cube coordinates, also used for the three windows
   typedef struct packed {
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } coord3_type;

   // Control that travels with a hit word along the chain
   typedef struct packed {
      logic live;     // a hit word occupies this stage
      logic clear;    // first of event: cells drop their track
      logic claimed;  // some cell already took the hit
      logic opened;   // the claiming cell started a new track
   } tok_flags_type;

endpackage

// ===== src/tohc_cell.sv =====
// One track slot: holds the last position of one track and compares the passing hit.
module tohc_cell #(
   parameter int ID_W     = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tohc_pkg::coord3_type   win,
   input  tohc_pkg::tok_flags_type flags_in,
   input  tohc_pkg::coord3_type   hit_in,
   input  logic [ID_W-1:0]        id_in,
   output tohc_pkg::tok_flags_type flags_out,
   output tohc_pkg::coord3_type   hit_out,
   output logic [ID_W-1:0]        id_out
);
   import tohc_pkg::*;

   logic          valid_ff, valid_in;
   coord3_type    pos_ff, pos_in;
   tok_flags_type flags_ff, flags_in_nx;
   coord3_type    hit_ff;
   logic [ID_W-1:0] id_ff, id_nx;

   logic       valid_eff;
   logic       near;
   logic [COORD_W-1:0] dx, dy, dz;

   // Absolute distances per axis
   assign dx = (hit_in.x > pos_ff.x) ? hit_in.x - pos_ff.x : pos_ff.x - hit_in.x;
   assign dy = (hit_in.y > pos_ff.y) ? hit_in.y - pos_ff.y : pos_ff.y - hit_in.y;
   assign dz = (hit_in.z > pos_ff.z) ? hit_in.z - pos_ff.z : pos_ff.z - hit_in.z;

   assign valid_eff = valid_ff && !flags_in.clear;
   assign near      = (dx <= win.x) && (dy <= win.y) && (dz <= win.z);

   // Join, open or pass
   always_comb begin
      valid_in    = valid_ff;
      pos_in      = pos_ff;
      flags_in_nx = flags_in;
      id_nx       = id_in;
      if (flags_in.live) begin
         if (flags_in.clear) begin
            valid_in = 1'b0;
         end
         if (!flags_in.claimed && valid_eff && near) begin
            pos_in              = hit_in;
            flags_in_nx.claimed = 1'b1;
            flags_in_nx.opened  = 1'b0;
            id_nx               = ID_W'(CELL_IDX);
         end else if (!flags_in.claimed && !valid_eff) begin
            // first free slot: table entries stay a contiguous prefix
            pos_in              = hit_in;
            valid_in            = 1'b1;
            flags_in_nx.claimed = 1'b1;
            flags_in_nx.opened  = 1'b1;
            id_nx               = ID_W'(CELL_IDX);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         flags_ff <= flags_in_nx;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      hit_ff <= hit_in;
      id_ff  <= id_nx;
   end

   assign flags_out = flags_ff;
   assign hit_out   = hit_ff;
   assign id_out    = id_ff;

endmodule

// ===== src/time_ordered_hit_chainer.sv =====
// An accepted hit word passes through the registers of every track cell before rsp_valid shows it.
// The block takes one hit at a time; the hit word walks the row of track cells,
// one cell per cycle, and busy stays high until it reaches the last cell's output.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active high) empties the track table and sets all windows to 1.
module time_ordered_hit_chainer #(
   parameter int MAX_TRACKS     = 64,
   parameter int CUBES_PER_AXIS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tohc_pkg::COORD_W-1:0]       req_hit_x,
   input  logic [tohc_pkg::COORD_W-1:0]       req_hit_y,
   input  logic [tohc_pkg::COORD_W-1:0]       req_hit_z,
   input  logic                               req_first_of_event,
   output logic                               rsp_valid,
   output logic [tohc_pkg::TRACK_ID_W-1:0]    rsp_track_id,
   output logic                               rsp_opened_track,
   output logic                               rsp_dropped,
   input  logic                               csr_we,
   input  logic [tohc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tohc_pkg::WIN_W-1:0]         csr_wdata
);
   import tohc_pkg::*;

   localparam int ID_W         = $clog2(MAX_TRACKS);
   localparam int MAX_COORD_I  = (CUBES_PER_AXIS - 1 > 255) ? 255 : CUBES_PER_AXIS - 1;
   localparam logic [COORD_W-1:0] MaxCoord = COORD_W'(MAX_COORD_I);

   coord3_type    win_ff;
   logic          busy_ff;
   logic          accept;
   tok_flags_type chain_flags [MAX_TRACKS+1];
   coord3_type    chain_hit   [MAX_TRACKS+1];
   logic [ID_W-1:0] chain_id  [MAX_TRACKS+1];
   tok_flags_type last_flags;

   // Window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.x <= WIN_RESET;
         win_ff.y <= WIN_RESET;
         win_ff.z <= WIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_WINDOW: win_ff.x <= csr_wdata;
            CSR_Y_WINDOW: win_ff.y <= csr_wdata;
            CSR_Z_WINDOW: win_ff.z <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign last_flags = chain_flags[MAX_TRACKS];
   assign accept     = start && !busy;
   assign busy       = busy_ff && !last_flags.live;

   // Busy while a hit word is in the row
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (last_flags.live) begin
         busy_ff <= 1'b0;
      end
   end

   // Injection into the first cell, coordinates saturated to the grid
   assign chain_flags[0] = '{live: accept, clear: req_first_of_event,
                             claimed: 1'b0, opened: 1'b0};
   assign chain_hit[0]   = '{z: (req_hit_z > MaxCoord) ? MaxCoord : req_hit_z,
                             y: (req_hit_y > MaxCoord) ? MaxCoord : req_hit_y,
                             x: (req_hit_x > MaxCoord) ? MaxCoord : req_hit_x};
   assign chain_id[0]    = '0;

   // Row of track cells
   for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
      tohc_cell #(
         .ID_W     (ID_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .win       (win_ff),
         .flags_in  (chain_flags[i]),
         .hit_in    (chain_hit[i]),
         .id_in     (chain_id[i]),
         .flags_out (chain_flags[i+1]),
         .hit_out   (chain_hit[i+1]),
         .id_out    (chain_id[i+1])
      );
   end

   // Result word straight from the last cell's registers
   assign rsp_valid        = last_flags.live;
   assign rsp_track_id     = last_flags.claimed ? TRACK_ID_W'(chain_id[MAX_TRACKS]) : '0;
   assign rsp_opened_track = last_flags.claimed && last_flags.opened;
   assign rsp_dropped      = !last_flags.claimed;

endmodule

// ===== src/tohc_checker.sv =====
// Port-level checks for the hit chainer.
`include "time_ordered_hit_chainer_assert.svh"

module tohc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [tohc_pkg::TRACK_ID_W-1:0]    rsp_track_id,
   input logic                               rsp_opened_track,
   input logic                               rsp_dropped
);

   // an accepted word keeps the block busy in the next cycle
   `TOHC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // a result only ends a busy period
   `TOHC_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))

   // a dropped hit reports track 0 and no new track
   `TOHC_ASSERT_IMPLY(a_drop_word, clock, reset, rsp_valid && rsp_dropped,
      rsp_track_id == '0 && !rsp_opened_track)

   // result words never come in adjacent cycles
   `TOHC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind time_ordered_hit_chainer tohc_checker u_tohc_checker (.*);

// ===== test/hit_chain_checker.sv =====
module hit_chain_checker #(
   parameter int MAX_TRACKS     = 64,
   parameter int CUBES_PER_AXIS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [tohc_pkg::COORD_W-1:0]    req_hit_x,
   input  logic [tohc_pkg::COORD_W-1:0]    req_hit_y,
   input  logic [tohc_pkg::COORD_W-1:0]    req_hit_z,
   input  logic                            req_first_of_event,
   input  logic                            rsp_valid,
   input  logic [tohc_pkg::TRACK_ID_W-1:0] rsp_track_id,
   input  logic                            rsp_opened_track,
   input  logic                            rsp_dropped,
   input  logic                            csr_we,
   input  logic [tohc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tohc_pkg::WIN_W-1:0]      csr_wdata,
   output int                              error_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tohc_pkg::*;

   // what the block must report for one hit word
   typedef struct packed {
      logic [TRACK_ID_W-1:0] track_id;
      logic                  opened;
      logic                  dropped;
   } track_verdict_type;

   coord3_type        track_tail [MAX_TRACKS];
   int                open_tracks = 0;
   coord3_type        window;
   track_verdict_type verdicts [$];
   int                mismatches = 0;

   // coordinates past the cube grid saturate to the last cube
   function automatic logic [COORD_W-1:0] clamp_axis(logic [COORD_W-1:0] v);
      if (int'(v) > CUBES_PER_AXIS - 1) return COORD_W'(CUBES_PER_AXIS - 1);
      return v;
   endfunction

   function automatic logic axis_close(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                       logic [WIN_W-1:0] w);
      logic [COORD_W-1:0] gap;
      gap = (a > b) ? a - b : b - a;
      return gap <= w;
   endfunction

   // Chain one hit into the track table: first close track in creation order wins,
   // otherwise a new track, otherwise dropped with the table untouched.
   function automatic track_verdict_type assign_track(coord3_type hit, logic clear);
      track_verdict_type v;
      v = '0;
      if (clear) open_tracks = 0;
      for (int k = 0; k < open_tracks; k++) begin
         if (axis_close(hit.x, track_tail[k].x, window.x) &&
             axis_close(hit.y, track_tail[k].y, window.y) &&
             axis_close(hit.z, track_tail[k].z, window.z)) begin
            track_tail[k] = hit;
            v.track_id = TRACK_ID_W'(k);
            return v;
         end
      end
      if (open_tracks < MAX_TRACKS) begin
         track_tail[open_tracks] = hit;
         v.track_id = TRACK_ID_W'(open_tracks);
         v.opened = 1'b1;
         open_tracks++;
      end else begin
         v.dropped = 1'b1;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      track_verdict_type want;
      track_verdict_type fresh;
      coord3_type        hit;
      if (reset) begin
         open_tracks = 0;
         window = {WIN_RESET, WIN_RESET, WIN_RESET};
         verdicts.delete();
      end else begin
         // window writes only happen while the block is idle
         if (csr_we) begin
            case (csr_index)
               CSR_X_WINDOW: window.x = csr_wdata;
               CSR_Y_WINDOW: window.y = csr_wdata;
               CSR_Z_WINDOW: window.z = csr_wdata;
               default: ;
            endcase
         end
         // accepted hit word
         if (start && !busy) begin
            hit.x = clamp_axis(req_hit_x);
            hit.y = clamp_axis(req_hit_y);
            hit.z = clamp_axis(req_hit_z);
            fresh = assign_track(hit, req_first_of_event);
            verdicts = {verdicts, fresh};
         end
         // result word against the oldest prediction
         if (rsp_valid) begin
            if (verdicts.size() == 0) begin
               $error("result word with no hit pending: track_id %0d", rsp_track_id);
               mismatches++;
            end else begin
               want = verdicts.pop_front();
               if (rsp_track_id !== want.track_id) begin
                  $error("track_id: expected %0d, got %0d", want.track_id, rsp_track_id);
                  mismatches++;
               end
               if (rsp_opened_track !== want.opened) begin
                  $error("opened_track: expected %0b, got %0b", want.opened, rsp_opened_track);
                  mismatches++;
               end
               if (rsp_dropped !== want.dropped) begin
                  $error("dropped: expected %0b, got %0b", want.dropped, rsp_dropped);
                  mismatches++;
               end
            end
         end
      end
      pending_count <= verdicts.size();
      error_count   <= mismatches;
   end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tohc_pkg::*;

   localparam int MAX_TRACKS     = 64;
   localparam int CUBES_PER_AXIS = 256;
   localparam int HIT_COUNT      = 1600;
   localparam int SEGMENTS       = 9;
   localparam int MAX_GAP        = 90;
   localparam int TRAILS         = 80;
   localparam int STALL_LIMIT    = 2000;
   // index 3 decodes to no register; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  start              = 1'b0;
   logic                  busy;
   logic [COORD_W-1:0]    req_hit_x          = '0;
   logic [COORD_W-1:0]    req_hit_y          = '0;
   logic [COORD_W-1:0]    req_hit_z          = '0;
   logic                  req_first_of_event = 1'b0;
   logic                  rsp_valid;
   logic [TRACK_ID_W-1:0] rsp_track_id;
   logic                  rsp_opened_track;
   logic                  rsp_dropped;
   logic                  csr_we             = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [WIN_W-1:0]      csr_wdata          = '0;
   int                    error_count;
   int                    pending_count;

   int                    idle_pct     = 0;
   int                    hits_sent    = 0;
   int                    quiet_cycles = 0;
   coord3_type            win          = {WIN_RESET, WIN_RESET, WIN_RESET};
   coord3_type            trail [TRAILS];

   time_ordered_hit_chainer #(
      .MAX_TRACKS    (MAX_TRACKS),
      .CUBES_PER_AXIS(CUBES_PER_AXIS)
   ) DUT (.*);

   hit_chain_checker #(
      .MAX_TRACKS    (MAX_TRACKS),
      .CUBES_PER_AXIS(CUBES_PER_AXIS)
   ) chain_chk (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: too long without a hit or a result word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("time_ordered_hit_chainer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one hit word, then maybe a sender gap
   task automatic send_hit(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic opens_event);
      start              <= 1'b1;
      req_hit_x          <= x;
      req_hit_y          <= y;
      req_hit_z          <= z;
      req_first_of_event <= opens_event;
      do @(posedge clock); while (busy);
      hits_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   // caller lowers csr_we after the last write of a batch
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   // move a track point; at least half the time it stays inside the window
   function automatic logic [COORD_W-1:0] drift(logic [COORD_W-1:0] p, logic [WIN_W-1:0] w);
      int reach;
      int v;
      reach = ($urandom_range(1) == 1) ? int'(w) : int'(w) + 2;
      v = int'(p) + int'($urandom_range(2 * reach)) - reach;
      if (v < 0) v = 0;
      if (v > CUBES_PER_AXIS - 1) v = CUBES_PER_AXIS - 1;
      return COORD_W'(v);
   endfunction

   function automatic logic [WIN_W-1:0] pick_window(int seg);
      int r;
      if (seg == 0) return '0;
      if (seg == 1) return '1;
      r = $urandom_range(99);
      if (r < 55) return WIN_W'($urandom_range(3));
      if (r < 70) return '0;
      if (r < 85) return '1;
      return WIN_W'($urandom);
   endfunction

   // One event: several particles walking through the cubes, plus some noise.
   // Most events open with the first-of-event flag, a few do not.
   task automatic run_event(int n_hits, int n_trails);
      int   k;
      logic opener;
      opener = ($urandom_range(9) != 0);
      for (int t = 0; t < n_trails; t++) trail[t] = 24'($urandom);
      for (int n = 0; n < n_hits; n++) begin
         if ($urandom_range(99) < 15) begin
            send_hit(8'($urandom), 8'($urandom), 8'($urandom),
                     (n == 0) ? opener : ($urandom_range(19) == 0));
         end else begin
            k = $urandom_range(n_trails - 1);
            trail[k].x = drift(trail[k].x, win.x);
            trail[k].y = drift(trail[k].y, win.y);
            trail[k].z = drift(trail[k].z, win.z);
            send_hit(trail[k].x, trail[k].y, trail[k].z, (n == 0) ? opener : 1'b0);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed hits under the reset windows of one cube
      send_hit(8'd0,   8'd0,   8'd0,   1'b0);  // empty table opens track 0
      send_hit(8'd1,   8'd1,   8'd1,   1'b0);  // joins track 0
      send_hit(8'd255, 8'd255, 8'd255, 1'b0);  // far corner opens track 1
      send_hit(8'd254, 8'd254, 8'd254, 1'b0);  // joins track 1
      send_hit(8'd3,   8'd1,   8'd1,   1'b0);  // two cubes off in x: new track
      send_hit(8'd2,   8'd1,   8'd1,   1'b0);  // close to two tracks, oldest wins
      send_hit(8'd2,   8'd2,   8'd2,   1'b0);
      send_hit(8'd0,   8'd255, 8'd0,   1'b0);
      send_hit(8'd255, 8'd0,   8'd255, 1'b0);
      send_hit(8'd255, 8'd0,   8'd253, 1'b0);  // off only in z
      send_hit(8'd2,   8'd2,   8'd2,   1'b1);  // new event clears the table
      send_hit(8'd4,   8'd2,   8'd2,   1'b1);  // back-to-back event starts
      send_hit(8'd170, 8'd85,  8'd170, 1'b0);
      send_hit(8'd85,  8'd170, 8'd85,  1'b0);

      // random events; long events with many particles fill the table
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         idle_pct = (seg < 3) ? 13 : (seg < 6) ? 80 : 0;
         win.x = pick_window(seg);
         win.y = pick_window(seg);
         win.z = pick_window(seg);
         write_reg(CSR_X_WINDOW, win.x);
         write_reg(CSR_Y_WINDOW, win.y);
         write_reg(CSR_Z_WINDOW, win.z);
         write_reg(CSR_SPARE, 8'($urandom));
         csr_we <= 1'b0;
         while (hits_sent < (seg + 1) * HIT_COUNT / SEGMENTS) begin
            if ($urandom_range(4) == 0) begin
               run_event($urandom_range(60, 90), $urandom_range(66, TRAILS));
            end else begin
               run_event($urandom_range(1, 24), $urandom_range(1, 6));
            end
         end
      end

      drain();
      repeat (MAX_TRACKS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("time_ordered_hit_chainer test passed");
      end else begin
         $display("time_ordered_hit_chainer test failed");
      end
      $finish;
   end

endmodule
